// ===== sv/vrot_pkg.sv =====
package vrot_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int CORDIC_STAGES   = 16;
    localparam int ANGLE_WIDTH     = 16;
    localparam int GUARD_BITS      = 60 - COORD_WIDTH;
    localparam int ACC_WIDTH       = 64;
    localparam int ANG_ACC_WIDTH   = 32;
    localparam int STAGE_IDX_WIDTH = 5;
    localparam int TABLE_LEN       = 24;
    localparam int EXT_WIDTH       = COORD_WIDTH + 1;
    localparam int GAIN_WIDTH      = GUARD_BITS + 1;
    localparam int OP_WIDTH        = 2;

    localparam int S_DATA_WIDTH = ((3 * COORD_WIDTH + ANGLE_WIDTH + 7) / 8) * 8;
    localparam int M_DATA_WIDTH = ((3 * COORD_WIDTH + 7) / 8) * 8;

    localparam logic [43:0] GAIN_Q44 = 44'd10682906608694;
    localparam logic [GAIN_WIDTH-1:0] GAIN = GAIN_WIDTH'(GAIN_Q44 >> (44 - GUARD_BITS));

    typedef enum logic [OP_WIDTH-1:0] {
        OP_AXIS_X = 2'd0,
        OP_AXIS_Y = 2'd1,
        OP_AXIS_Z = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef logic signed [COORD_WIDTH-1:0]   coord_t;
    typedef logic signed [EXT_WIDTH-1:0]     ext_t;
    typedef logic signed [ACC_WIDTH-1:0]     acc_t;
    typedef logic signed [ANG_ACC_WIDTH-1:0] angacc_t;
    typedef logic [STAGE_IDX_WIDTH-1:0]      stage_idx_t;

    typedef struct packed {
        op_t    op;
        coord_t x;
        coord_t y;
        coord_t z;
    } meta_t;

    typedef struct packed {
        meta_t   meta;
        ext_t    a;
        ext_t    b;
        angacc_t ang;
    } prep_t;

    typedef struct packed {
        meta_t   meta;
        acc_t    x;
        acc_t    y;
        angacc_t ang;
    } rot_t;

    function automatic angacc_t atan_turn(input stage_idx_t idx);
        angacc_t v;
        case (idx)
            5'd0:    v = 32'sh20000000;
            5'd1:    v = 32'sh12E4051D;
            5'd2:    v = 32'sh09FB385B;
            5'd3:    v = 32'sh051111D4;
            5'd4:    v = 32'sh028B0D43;
            5'd5:    v = 32'sh0145D7E1;
            5'd6:    v = 32'sh00A2F61E;
            5'd7:    v = 32'sh00517C55;
            5'd8:    v = 32'sh0028BE53;
            5'd9:    v = 32'sh00145F2E;
            5'd10:   v = 32'sh000A2F98;
            5'd11:   v = 32'sh000517CC;
            5'd12:   v = 32'sh00028BE6;
            5'd13:   v = 32'sh000145F3;
            5'd14:   v = 32'sh0000A2F9;
            5'd15:   v = 32'sh0000517C;
            5'd16:   v = 32'sh000028BE;
            5'd17:   v = 32'sh0000145F;
            5'd18:   v = 32'sh00000A2F;
            5'd19:   v = 32'sh00000517;
            5'd20:   v = 32'sh0000028B;
            5'd21:   v = 32'sh00000145;
            5'd22:   v = 32'sh000000A2;
            5'd23:   v = 32'sh00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/vrot_prep_cell.sv =====
module vrot_prep_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  vrot_pkg::op_t          op,
    input  vrot_pkg::coord_t       in_x,
    input  vrot_pkg::coord_t       in_y,
    input  vrot_pkg::coord_t       in_z,
    input  logic [vrot_pkg::ANGLE_WIDTH-1:0] turn_angle,
    output logic                   out_valid,
    input  logic                   out_ready,
    output vrot_pkg::prep_t        out_data
);

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    logic                               valid_reg, valid_next;
    vrot_pkg::prep_t                    data_reg, data_next, calc;
    vrot_pkg::coord_t                   a_sel, b_sel;
    vrot_pkg::ext_t                     a_ext, b_ext;
    logic [vrot_pkg::ANGLE_WIDTH-1:0]   ang_sum;
    quad_t                              quad;
    logic signed [13:0]                 resid;

    always_comb begin
        case (op)
            vrot_pkg::OP_AXIS_X: begin
                a_sel = in_y;
                b_sel = in_z;
            end
            vrot_pkg::OP_AXIS_Y: begin
                a_sel = in_x;
                b_sel = in_z;
            end
            default: begin
                a_sel = in_x;
                b_sel = in_y;
            end
        endcase
        a_ext   = {a_sel[vrot_pkg::COORD_WIDTH-1], a_sel};
        b_ext   = {b_sel[vrot_pkg::COORD_WIDTH-1], b_sel};
        ang_sum = turn_angle + 16'd8192;
        quad    = quad_t'(ang_sum[15:14]);
        resid   = {~ang_sum[13], ang_sum[12:0]};

        calc.meta.op = op;
        calc.meta.x  = in_x;
        calc.meta.y  = in_y;
        calc.meta.z  = in_z;
        calc.ang     = vrot_pkg::ANG_ACC_WIDTH'($signed({resid, 16'h0000}));
        case (quad)
            QUAD_1: begin
                calc.a = -b_ext;
                calc.b = a_ext;
            end
            QUAD_2: begin
                calc.a = -a_ext;
                calc.b = -b_ext;
            end
            QUAD_3: begin
                calc.a = b_ext;
                calc.b = -a_ext;
            end
            default: begin
                calc.a = a_ext;
                calc.b = b_ext;
            end
        endcase

        in_ready   = !valid_reg || out_ready;
        valid_next = in_ready ? in_valid : valid_reg;
        data_next  = (in_ready && in_valid) ? calc : data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/vrot_scale_cell.sv =====
module vrot_scale_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  vrot_pkg::prep_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output vrot_pkg::rot_t   out_data
);

    localparam int PROD_WIDTH = vrot_pkg::EXT_WIDTH + vrot_pkg::GAIN_WIDTH;

    logic                          valid_reg, valid_next;
    vrot_pkg::rot_t                data_reg, data_next, calc;
    logic signed [PROD_WIDTH-1:0]  prod_a, prod_b;
    logic signed [vrot_pkg::GAIN_WIDTH-1:0] gain_s;

    always_comb begin
        gain_s = $signed(vrot_pkg::GAIN);
        prod_a = PROD_WIDTH'(in_data.a) * PROD_WIDTH'(gain_s);
        prod_b = PROD_WIDTH'(in_data.b) * PROD_WIDTH'(gain_s);

        calc.meta = in_data.meta;
        calc.x    = vrot_pkg::ACC_WIDTH'(prod_a);
        calc.y    = vrot_pkg::ACC_WIDTH'(prod_b);
        calc.ang  = in_data.ang;

        in_ready   = !valid_reg || out_ready;
        valid_next = in_ready ? in_valid : valid_reg;
        data_next  = (in_ready && in_valid) ? calc : data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/vrot_cordic_cell.sv =====
module vrot_cordic_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  vrot_pkg::stage_idx_t  stage_idx,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  vrot_pkg::rot_t        in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output vrot_pkg::rot_t        out_data
);

    logic               valid_reg, valid_next;
    vrot_pkg::rot_t     data_reg, data_next, calc;
    vrot_pkg::acc_t     dx, dy;
    vrot_pkg::angacc_t  step_ang;

    always_comb begin
        dx       = in_data.y >>> stage_idx;
        dy       = in_data.x >>> stage_idx;
        step_ang = vrot_pkg::atan_turn(stage_idx);

        calc.meta = in_data.meta;
        if (in_data.ang >= 0) begin
            calc.x   = in_data.x - dx;
            calc.y   = in_data.y + dy;
            calc.ang = in_data.ang - step_ang;
        end else begin
            calc.x   = in_data.x + dx;
            calc.y   = in_data.y - dy;
            calc.ang = in_data.ang + step_ang;
        end

        in_ready   = !valid_reg || out_ready;
        valid_next = in_ready ? in_valid : valid_reg;
        data_next  = (in_ready && in_valid) ? calc : data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/vrot_out_cell.sv =====
module vrot_out_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  vrot_pkg::rot_t    in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output vrot_pkg::coord_t  out_x,
    output vrot_pkg::coord_t  out_y,
    output vrot_pkg::coord_t  out_z,
    output logic              saturated
);

    localparam vrot_pkg::acc_t HALF      = vrot_pkg::acc_t'(1) <<< (vrot_pkg::GUARD_BITS - 1);
    localparam vrot_pkg::acc_t COORD_MAX =
        (vrot_pkg::acc_t'(1) <<< (vrot_pkg::COORD_WIDTH - 1)) - vrot_pkg::acc_t'(1);
    localparam vrot_pkg::acc_t COORD_MIN = -COORD_MAX - vrot_pkg::acc_t'(1);

    logic              valid_reg, valid_next;
    vrot_pkg::coord_t  x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic              sat_reg, sat_next;
    vrot_pkg::acc_t    first_r, second_r;
    vrot_pkg::coord_t  first_c, second_c;
    logic              first_s, second_s;
    vrot_pkg::coord_t  cx, cy, cz;
    logic              cs;

    always_comb begin
        first_r  = (in_data.x + HALF) >>> vrot_pkg::GUARD_BITS;
        second_r = (in_data.y + HALF) >>> vrot_pkg::GUARD_BITS;

        first_s = 1'b1;
        if (first_r > COORD_MAX) begin
            first_c = vrot_pkg::COORD_WIDTH'(COORD_MAX);
        end else if (first_r < COORD_MIN) begin
            first_c = vrot_pkg::COORD_WIDTH'(COORD_MIN);
        end else begin
            first_c = vrot_pkg::COORD_WIDTH'(first_r);
            first_s = 1'b0;
        end

        second_s = 1'b1;
        if (second_r > COORD_MAX) begin
            second_c = vrot_pkg::COORD_WIDTH'(COORD_MAX);
        end else if (second_r < COORD_MIN) begin
            second_c = vrot_pkg::COORD_WIDTH'(COORD_MIN);
        end else begin
            second_c = vrot_pkg::COORD_WIDTH'(second_r);
            second_s = 1'b0;
        end

        cx = in_data.meta.x;
        cy = in_data.meta.y;
        cz = in_data.meta.z;
        cs = first_s || second_s;
        case (in_data.meta.op)
            vrot_pkg::OP_AXIS_X: begin
                cy = first_c;
                cz = second_c;
            end
            vrot_pkg::OP_AXIS_Y: begin
                cx = first_c;
                cz = second_c;
            end
            vrot_pkg::OP_AXIS_Z: begin
                cx = first_c;
                cy = second_c;
            end
            default: begin
                cs = 1'b0;
            end
        endcase

        in_ready   = !valid_reg || out_ready;
        valid_next = in_ready ? in_valid : valid_reg;
        if (in_ready && in_valid) begin
            x_next   = cx;
            y_next   = cy;
            z_next   = cz;
            sat_next = cs;
        end else begin
            x_next   = x_reg;
            y_next   = y_reg;
            z_next   = z_reg;
            sat_next = sat_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        sat_reg <= sat_next;
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign saturated = sat_reg;

    a_axis_x_passes: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready && in_data.meta.op == vrot_pkg::OP_AXIS_X
        |=> x_reg == $past(in_data.meta.x))
        else $error("X component altered by a rotation about the X axis.");

    a_none_no_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready && in_data.meta.op == vrot_pkg::OP_NONE
        |=> !sat_reg && z_reg == $past(in_data.meta.z) && x_reg == $past(in_data.meta.x))
        else $error("Unrotated transaction was changed or flagged.");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !out_ready
        |=> valid_reg && $stable(x_reg) && $stable(y_reg) && $stable(sat_reg))
        else $error("Result register changed while stalled.");

endmodule

// ===== sv/vec3_axis_rotation_core.sv =====
// Channel  Direction  tdata (low bit up)               tuser
// s_axis   in         in_x, in_y, in_z, turn_angle     op
// m_axis   out        out_x, out_y, out_z              saturated
//
// One transaction is accepted per cycle while no stall on m_axis has backed up to s_axis.
// Each one passes an axis-select cell and a gain-multiply cell, then the row of CORDIC
// cells, one rotation step per cell, and last a rounding cell.
// Every cell holds its own valid bit, which the synchronous reset clears.
// A stall on m_axis holds only the full cells; empty cells further up keep filling.
module vec3_axis_rotation_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // in_x, in_y, in_z, turn_angle
    input  logic [vrot_pkg::S_DATA_WIDTH-1:0] s_axis_tdata,
    // op
    input  logic [vrot_pkg::OP_WIDTH-1:0]     s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_x, out_y, out_z
    output logic [vrot_pkg::M_DATA_WIDTH-1:0] m_axis_tdata,
    // saturated
    output logic                              m_axis_tuser
);

    localparam int CW = vrot_pkg::COORD_WIDTH;
    localparam int NS = vrot_pkg::CORDIC_STAGES;

    logic             prep_valid, prep_ready;
    vrot_pkg::prep_t  prep_data;
    logic             chain_valid [NS+1];
    logic             chain_ready [NS+1];
    vrot_pkg::rot_t   chain_data  [NS+1];
    vrot_pkg::coord_t res_x, res_y, res_z;

    vrot_prep_cell u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .op         (vrot_pkg::op_t'(s_axis_tuser)),
        .in_x       (s_axis_tdata[CW-1:0]),
        .in_y       (s_axis_tdata[2*CW-1:CW]),
        .in_z       (s_axis_tdata[3*CW-1:2*CW]),
        .turn_angle (s_axis_tdata[3*CW+vrot_pkg::ANGLE_WIDTH-1:3*CW]),
        .out_valid  (prep_valid),
        .out_ready  (prep_ready),
        .out_data   (prep_data)
    );

    vrot_scale_cell u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    for (genvar i = 0; i < NS; i++) begin : g_stage
        vrot_cordic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .stage_idx (vrot_pkg::STAGE_IDX_WIDTH'(i)),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    vrot_out_cell u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (chain_valid[NS]),
        .in_ready  (chain_ready[NS]),
        .in_data   (chain_data[NS]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_x     (res_x),
        .out_y     (res_y),
        .out_z     (res_z),
        .saturated (m_axis_tuser)
    );

    assign m_axis_tdata = vrot_pkg::M_DATA_WIDTH'({res_z, res_y, res_x});

endmodule

// ===== test/tb.sv =====
module tb;
    import vrot_pkg::*;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   sat;
    } rotated_t;

    typedef struct {
        coord_t first;
        coord_t second;
        logic   sat;
    } plane_pair_t;

    localparam longint GAIN_FULL = 64'sd10682906608694;
    localparam longint COORD_MAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam longint ARCTAN_TURN [24] = '{
        64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C,
        64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
    };

    logic                    aclk;
    logic                    aresetn       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [S_DATA_WIDTH-1:0] s_axis_tdata  = '0;
    logic [OP_WIDTH-1:0]     s_axis_tuser  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [M_DATA_WIDTH-1:0] m_axis_tdata;
    logic                    m_axis_tuser;

    rotated_t pending_vectors[$];
    int       failures    = 0;
    bit       steady_flow = 1'b0;

    vec3_axis_rotation_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5000000;
        $display("tb failed");
        $finish;
    end

    function automatic coord_t clamp_coord(input longint v);
        if (v > COORD_MAX) begin
            return coord_t'(COORD_MAX);
        end
        if (v < COORD_MIN) begin
            return coord_t'(COORD_MIN);
        end
        return coord_t'(v);
    endfunction

    // Quarter turns are taken exactly; CORDIC only handles the residual of
    // at most an eighth of a turn either way.
    function automatic plane_pair_t turn_plane(input coord_t a, input coord_t b,
                                               input logic [ANGLE_WIDTH-1:0] ang);
        plane_pair_t res;
        longint      gain, sa, sb, px, py, pz, dx, dy, half, rf, rs;
        logic [16:0] ang_ext;
        gain    = GAIN_FULL >>> (44 - GUARD_BITS);
        sa      = longint'(a) * gain;
        sb      = longint'(b) * gain;
        ang_ext = {1'b0, ang} + 17'd8192;
        pz      = (longint'(ang_ext[13:0]) - 8192) * 65536;
        case (ang_ext[15:14])
            2'd1: begin
                px = -sb;
                py = sa;
            end
            2'd2: begin
                px = -sa;
                py = -sb;
            end
            2'd3: begin
                px = sb;
                py = -sa;
            end
            default: begin
                px = sa;
                py = sb;
            end
        endcase
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            dx = py >>> i;
            dy = px >>> i;
            if (pz >= 0) begin
                px = px - dx;
                py = py + dy;
                pz = pz - ARCTAN_TURN[i];
            end else begin
                px = px + dx;
                py = py - dy;
                pz = pz + ARCTAN_TURN[i];
            end
        end
        half       = 64'sd1 <<< (GUARD_BITS - 1);
        rf         = (px + half) >>> GUARD_BITS;
        rs         = (py + half) >>> GUARD_BITS;
        res.first  = clamp_coord(rf);
        res.second = clamp_coord(rs);
        res.sat    = (rf > COORD_MAX) || (rf < COORD_MIN) ||
                     (rs > COORD_MAX) || (rs < COORD_MIN);
        return res;
    endfunction

    function automatic rotated_t rotate_vector(input op_t op, input coord_t vx,
                                               input coord_t vy, input coord_t vz,
                                               input logic [ANGLE_WIDTH-1:0] ang);
        rotated_t    res;
        plane_pair_t pair;
        res = '{x: vx, y: vy, z: vz, sat: 1'b0};
        case (op)
            OP_AXIS_X: begin
                pair    = turn_plane(vy, vz, ang);
                res.y   = pair.first;
                res.z   = pair.second;
                res.sat = pair.sat;
            end
            OP_AXIS_Y: begin
                pair    = turn_plane(vx, vz, ang);
                res.x   = pair.first;
                res.z   = pair.second;
                res.sat = pair.sat;
            end
            OP_AXIS_Z: begin
                pair    = turn_plane(vx, vy, ang);
                res.x   = pair.first;
                res.y   = pair.second;
                res.sat = pair.sat;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end
        if (r < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic coord_t random_coord();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
            end
            4, 5, 6: begin
                v = 32'($signed(v) >>> $urandom_range(8, 24));
            end
            7: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0001;
                endcase
            end
            default: begin
                v[30:29] = v[31] ? 2'b00 : 2'b11;
            end
        endcase
        return coord_t'(v);
    endfunction

    function automatic logic [ANGLE_WIDTH-1:0] random_angle();
        if ($urandom_range(0, 3) == 0) begin
            return 16'($urandom_range(0, 7) * 8192 + $urandom_range(0, 6) - 3);
        end
        return 16'($urandom);
    endfunction

    function automatic op_t random_op();
        if ($urandom_range(0, 19) == 0) begin
            return OP_NONE;
        end
        return op_t'(2'($urandom_range(0, 2)));
    endfunction

    // Entered and left at a falling edge; tvalid stays high on return.
    task automatic send_vector(input op_t op, input coord_t vx, input coord_t vy,
                               input coord_t vz, input logic [ANGLE_WIDTH-1:0] ang);
        int gap;
        gap = (steady_flow || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ang, vz, vy, vx};
        s_axis_tuser  <= op;
        do @(posedge aclk); while (!s_axis_tready);
        pending_vectors.push_back(rotate_vector(op, vx, vy, vz, ang));
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_vectors.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic test_axis_quadrants();
        for (int a = 0; a < 3; a++) begin
            for (int q = 0; q < 4; q++) begin
                send_vector(op_t'(2'(a)), 32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000,
                            16'(q * 16384));
            end
        end
    endtask

    task automatic test_field_extremes();
        send_vector(OP_AXIS_Z, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 16'd8192);
        send_vector(OP_AXIS_X, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'd8191);
        send_vector(OP_AXIS_Y, 32'sh7FFF_FFFF, 32'sh0, 32'sh8000_0000, 16'd0);
        send_vector(OP_AXIS_Z, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh1, 16'd65535);
        send_vector(OP_AXIS_X, -32'sh1, 32'sh8000_0000, -32'sh1, 16'd32768);
        send_vector(OP_AXIS_Y, 32'sh1, -32'sh1, 32'sh7FFF_FFFF, 16'd57344);
        send_vector(OP_AXIS_Z, 32'sh0, 32'sh0, 32'sh0, 16'd24576);
        send_vector(OP_AXIS_X, 32'sh1234_5678, 32'sh7FFF_0000, 32'sh7FFF_0000, 16'd40960);
    endtask

    task automatic test_no_rotation();
        send_vector(OP_NONE, 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh1, 16'd12345);
        send_vector(OP_NONE, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 16'd65535);
    endtask

    task automatic test_drain_pause();
        repeat (12) send_vector(random_op(), random_coord(), random_coord(),
                                random_coord(), random_angle());
        wait_drained();
        repeat (12) send_vector(random_op(), random_coord(), random_coord(),
                                random_coord(), random_angle());
    endtask

    task automatic test_random_stream();
        for (int n = 0; n < 1500; n++) begin
            steady_flow = (n >= 600 && n < 800);
            send_vector(random_op(), random_coord(), random_coord(), random_coord(),
                        random_angle());
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        forever begin
            @(negedge aclk);
            m_axis_tready <= 1'b1;
            if (!steady_flow && $urandom_range(0, 99) < 20) begin
                repeat (pick_gap()) begin
                    @(negedge aclk);
                    m_axis_tready <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        rotated_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_vectors.size() == 0) begin
                $error("transaction on m_axis with no result expected");
                failures++;
            end else begin
                want = pending_vectors.pop_front();
                if (coord_t'(m_axis_tdata[31:0]) !== want.x) begin
                    $error("out_x: expected %0d, got %0d", want.x,
                           coord_t'(m_axis_tdata[31:0]));
                    failures++;
                end
                if (coord_t'(m_axis_tdata[63:32]) !== want.y) begin
                    $error("out_y: expected %0d, got %0d", want.y,
                           coord_t'(m_axis_tdata[63:32]));
                    failures++;
                end
                if (coord_t'(m_axis_tdata[95:64]) !== want.z) begin
                    $error("out_z: expected %0d, got %0d", want.z,
                           coord_t'(m_axis_tdata[95:64]));
                    failures++;
                end
                if (m_axis_tuser !== want.sat) begin
                    $error("saturated: expected %0d, got %0d", want.sat, m_axis_tuser);
                    failures++;
                end
            end
        end
    end

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_axis_quadrants();
        test_field_extremes();
        test_no_rotation();
        test_drain_pause();
        test_random_stream();
        wait_drained();
        repeat (CORDIC_STAGES + 10) @(posedge aclk);
        if (failures == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
